// ----- src/amcs_pkg.sv -----
// ----------------------------------------------------------------------------
// amcs_pkg
// Shared types and constants of the adaptive modulation and coding selector.
// ----------------------------------------------------------------------------
`default_nettype none

package amcs_pkg;

    localparam int SNR_BITS        = 12;
    localparam int HYST_BITS       = 10;
    localparam int MIN_FRAMES_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int FRAME_COUNT_BITS_DEFAULT = 20;

    typedef logic signed [SNR_BITS-1:0]      snr_t;
    typedef logic [HYST_BITS-1:0]            hyst_t;
    typedef logic [MIN_FRAMES_BITS-1:0]      min_frames_t;
    typedef logic [CFG_DATA_BITS-1:0]        cfg_data_t;
    typedef logic [CFG_INDEX_BITS-1:0]       cfg_index_t;

    typedef enum logic [1:0] {
        MOD_BPSK  = 2'd0,
        MOD_QPSK  = 2'd1,
        MOD_QAM16 = 2'd2,
        MOD_QAM64 = 2'd3
    } mod_t;

    typedef enum logic [2:0] {
        RATE_1_4 = 3'd0,
        RATE_1_2 = 3'd1,
        RATE_2_3 = 3'd2,
        RATE_3_4 = 3'd3,
        RATE_5_6 = 3'd4
    } rate_t;

    localparam cfg_index_t REG_HYSTERESIS_LEVEL  = 1'd0;
    localparam cfg_index_t REG_MIN_STABLE_FRAMES = 1'd1;

    localparam hyst_t       HYST_RESET       = 10'd48;
    localparam min_frames_t MIN_FRAMES_RESET = 16'd5;
    localparam mod_t        MOD_RESET        = MOD_QAM64;
    localparam rate_t       RATE_RESET       = RATE_3_4;

    // Thresholds in 1/16 dB: 48, 44, 40, 36, 34, 32 and 28 dB
    localparam snr_t THR_48DB = 12'sd768;
    localparam snr_t THR_44DB = 12'sd704;
    localparam snr_t THR_40DB = 12'sd640;
    localparam snr_t THR_36DB = 12'sd576;
    localparam snr_t THR_34DB = 12'sd544;
    localparam snr_t THR_32DB = 12'sd512;
    localparam snr_t THR_28DB = 12'sd448;

    localparam int STABLE_MULTIPLIER = 10;

endpackage

`default_nettype wire

// ----- src/amcs_meas_if.sv -----
// ----------------------------------------------------------------------------
// amcs_meas_if
// Measurement channel: one SNR word per frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface amcs_meas_if;
    logic             valid;
    logic             ready;
    amcs_pkg::snr_t   snr_level;

    modport source (output valid, output snr_level, input ready);
    modport sink   (input valid, input snr_level, output ready);
endinterface

`default_nettype wire

// ----- src/amcs_sel_if.sv -----
// ----------------------------------------------------------------------------
// amcs_sel_if
// Selection channel: switch flag, current and recommended mode per frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface amcs_sel_if;
    logic             valid;
    logic             ready;
    logic             switched;
    amcs_pkg::mod_t   current_modulation;
    amcs_pkg::rate_t  current_code_rate;
    amcs_pkg::mod_t   recommended_modulation;
    amcs_pkg::rate_t  recommended_code_rate;

    modport source (output valid, output switched, output current_modulation,
                    output current_code_rate, output recommended_modulation,
                    output recommended_code_rate, input ready);
    modport sink   (input valid, input switched, input current_modulation,
                    input current_code_rate, input recommended_modulation,
                    input recommended_code_rate, output ready);
endinterface

`default_nettype wire

// ----- src/adaptive_modcod_selector_unit.sv -----
// ----------------------------------------------------------------------------
// adaptive_modcod_selector_unit
// Maps per-frame SNR to a modulation and code rate, with hysteresis.
// ----------------------------------------------------------------------------
// One SNR word is taken per cycle unless the input side stalls. Each word lands
// in an input register; from it the threshold table, the SNR change against
// the last switch and the frame count compare are evaluated, and the mode
// state and the result register update together as the word advances. The
// input side stalls only when both the input and the result register hold a
// word and the result is not taken. Registers are written on cfg_we (index 0
// hysteresis_level, index 1 min_stable_frames); the user must write them only
// while idle, which the block itself does not enforce.
`default_nettype none

module adaptive_modcod_selector_unit #(
    parameter int FRAME_COUNT_BITS = amcs_pkg::FRAME_COUNT_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire amcs_pkg::cfg_index_t cfg_index,
    input  wire amcs_pkg::cfg_data_t  cfg_data,
    amcs_meas_if.sink                 meas,
    amcs_sel_if.source                sel
);

    localparam int LIMIT_BITS = amcs_pkg::MIN_FRAMES_BITS + 4;
    localparam int CMP_BITS   = (FRAME_COUNT_BITS > LIMIT_BITS) ? FRAME_COUNT_BITS
                                                                : LIMIT_BITS;
    localparam int SNR_BITS   = amcs_pkg::SNR_BITS;

    typedef logic [FRAME_COUNT_BITS-1:0] count_t;

    amcs_pkg::hyst_t       hyst_reg;
    amcs_pkg::min_frames_t min_frames_reg;

    amcs_pkg::mod_t  active_mod_reg,  active_mod_next;
    amcs_pkg::rate_t active_rate_reg, active_rate_next;
    amcs_pkg::snr_t  last_snr_reg,    last_snr_next;
    count_t          frames_reg,      frames_next;

    logic            in_valid_reg;
    amcs_pkg::snr_t  in_snr_reg;

    logic            out_valid_reg;
    logic            out_sw_reg,          out_sw_next;
    amcs_pkg::mod_t  out_table_mod_reg,   table_mod;
    amcs_pkg::rate_t out_table_rate_reg,  table_rate;

    logic out_free;
    logic advance;

    logic signed [SNR_BITS:0] diff;
    logic [SNR_BITS-1:0]      change;
    logic [LIMIT_BITS-1:0]    long_count;
    logic                     same_mode;
    logic                     allow;

    assign out_free   = !out_valid_reg || sel.ready;
    assign advance    = in_valid_reg && out_free;
    assign meas.ready = !in_valid_reg || out_free;

    // threshold table, strictly greater than
    always_comb
    begin
        if (in_snr_reg > amcs_pkg::THR_48DB)
        begin
            table_mod = amcs_pkg::MOD_QAM64; table_rate = amcs_pkg::RATE_5_6;
        end
        else if (in_snr_reg > amcs_pkg::THR_44DB)
        begin
            table_mod = amcs_pkg::MOD_QAM64; table_rate = amcs_pkg::RATE_3_4;
        end
        else if (in_snr_reg > amcs_pkg::THR_40DB)
        begin
            table_mod = amcs_pkg::MOD_QAM16; table_rate = amcs_pkg::RATE_3_4;
        end
        else if (in_snr_reg > amcs_pkg::THR_36DB)
        begin
            table_mod = amcs_pkg::MOD_QAM16; table_rate = amcs_pkg::RATE_2_3;
        end
        else if (in_snr_reg > amcs_pkg::THR_34DB)
        begin
            table_mod = amcs_pkg::MOD_QPSK;  table_rate = amcs_pkg::RATE_2_3;
        end
        else if (in_snr_reg > amcs_pkg::THR_32DB)
        begin
            table_mod = amcs_pkg::MOD_QPSK;  table_rate = amcs_pkg::RATE_1_2;
        end
        else if (in_snr_reg > amcs_pkg::THR_28DB)
        begin
            table_mod = amcs_pkg::MOD_BPSK;  table_rate = amcs_pkg::RATE_1_2;
        end
        else
        begin
            table_mod = amcs_pkg::MOD_BPSK;  table_rate = amcs_pkg::RATE_1_4;
        end
    end

    always_comb
    begin
        diff       = {in_snr_reg[SNR_BITS-1], in_snr_reg}
                   - {last_snr_reg[SNR_BITS-1], last_snr_reg};
        change     = diff[SNR_BITS] ? SNR_BITS'(-diff) : diff[SNR_BITS-1:0];
        long_count = LIMIT_BITS'(min_frames_reg)
                   * LIMIT_BITS'(amcs_pkg::STABLE_MULTIPLIER);
        same_mode  = (table_mod == active_mod_reg) && (table_rate == active_rate_reg);
        allow      = (change >= SNR_BITS'(hyst_reg))
                  || (CMP_BITS'(frames_reg) >= CMP_BITS'(long_count));

        active_mod_next  = active_mod_reg;
        active_rate_next = active_rate_reg;
        last_snr_next    = last_snr_reg;
        out_sw_next      = 1'b0;
        // saturate the frame counter
        frames_next      = (frames_reg == '1) ? frames_reg : frames_reg + 1'b1;

        if (!same_mode && allow)
        begin
            active_mod_next  = table_mod;
            active_rate_next = table_rate;
            last_snr_next    = in_snr_reg;
            frames_next      = '0;
            out_sw_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg        <= amcs_pkg::HYST_RESET;
            min_frames_reg  <= amcs_pkg::MIN_FRAMES_RESET;
            active_mod_reg  <= amcs_pkg::MOD_RESET;
            active_rate_reg <= amcs_pkg::RATE_RESET;
            last_snr_reg    <= '0;
            frames_reg      <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    amcs_pkg::REG_HYSTERESIS_LEVEL:
                        hyst_reg <= cfg_data[amcs_pkg::HYST_BITS-1:0];
                    amcs_pkg::REG_MIN_STABLE_FRAMES:
                        min_frames_reg <= cfg_data[amcs_pkg::MIN_FRAMES_BITS-1:0];
                    default: ;
                endcase
            end

            if (meas.ready)
            begin
                in_valid_reg <= meas.valid;
            end

            if (advance)
            begin
                active_mod_reg  <= active_mod_next;
                active_rate_reg <= active_rate_next;
                last_snr_reg    <= last_snr_next;
                frames_reg      <= frames_next;
            end

            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas.ready && meas.valid)
        begin
            in_snr_reg <= meas.snr_level;
        end
        if (advance)
        begin
            out_sw_reg         <= out_sw_next;
            out_table_mod_reg  <= table_mod;
            out_table_rate_reg <= table_rate;
        end
    end

    // current mode in the result equals the state written with it
    assign sel.valid                  = out_valid_reg;
    assign sel.switched               = out_sw_reg;
    assign sel.current_modulation     = active_mod_reg;
    assign sel.current_code_rate      = active_rate_reg;
    assign sel.recommended_modulation = out_table_mod_reg;
    assign sel.recommended_code_rate  = out_table_rate_reg;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench of the adaptive modulation and coding selector. SNR words go in
// through the measurement channel. A predictor of the mode state computes the
// switch flag, the current mode and the recommended mode of every accepted
// word. A checker compares each selection word, field by field, in order.
// Stimulus: table edges, zero and full-scale registers, an output stall that
// backs up the block, then phases of random settings with dwell sequences
// around the thresholds mixed with full-range noise.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FRAME_BITS     = FRAME_COUNT_BITS_DEFAULT;

    typedef struct {
        logic  switched;
        mod_t  cur_mod;
        rate_t cur_rate;
        mod_t  table_mod;
        rate_t table_rate;
    } sel_word_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    amcs_meas_if meas();
    amcs_sel_if  sel();

    adaptive_modcod_selector_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas),
        .sel       (sel)
    );

    // Mode state and register copies of the predictor
    mod_t                  mode_mod;
    rate_t                 mode_rate;
    snr_t                  snr_at_switch;
    logic [FRAME_BITS-1:0] frames_held;
    hyst_t                 hyst_level;
    min_frames_t           stable_frames;

    sel_word_t pending_sel[$];
    int        mismatch_count;
    int        idle_cycles;
    int        hold_request;
    bit        sender_idle;
    bit        receiver_idle;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void lookup_mode(input snr_t s, output mod_t m, output rate_t r);
        if (s > THR_48DB)
        begin
            m = MOD_QAM64;
            r = RATE_5_6;
        end
        else if (s > THR_44DB)
        begin
            m = MOD_QAM64;
            r = RATE_3_4;
        end
        else if (s > THR_40DB)
        begin
            m = MOD_QAM16;
            r = RATE_3_4;
        end
        else if (s > THR_36DB)
        begin
            m = MOD_QAM16;
            r = RATE_2_3;
        end
        else if (s > THR_34DB)
        begin
            m = MOD_QPSK;
            r = RATE_2_3;
        end
        else if (s > THR_32DB)
        begin
            m = MOD_QPSK;
            r = RATE_1_2;
        end
        else if (s > THR_28DB)
        begin
            m = MOD_BPSK;
            r = RATE_1_2;
        end
        else
        begin
            m = MOD_BPSK;
            r = RATE_1_4;
        end
    endfunction

    function automatic void bump_frames();
        // saturate at the counter maximum
        if (frames_held != '1)
            frames_held = frames_held + 1'b1;
    endfunction

    function automatic sel_word_t select_mode(input snr_t s);
        sel_word_t w;
        mod_t      m;
        rate_t     r;
        int        change;
        lookup_mode(s, m, r);
        w.switched = 1'b0;
        if (m == mode_mod && r == mode_rate)
            bump_frames();
        else
        begin
            change = int'(s) - int'(snr_at_switch);
            if (change < 0)
                change = -change;
            if (change >= int'(hyst_level) ||
                int'(frames_held) >= STABLE_MULTIPLIER * int'(stable_frames))
            begin
                mode_mod      = m;
                mode_rate     = r;
                snr_at_switch = s;
                frames_held   = '0;
                w.switched    = 1'b1;
            end
            else
                bump_frames();
        end
        w.cur_mod    = mode_mod;
        w.cur_rate   = mode_rate;
        w.table_mod  = m;
        w.table_rate = r;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HYSTERESIS_LEVEL)
            hyst_level = data[HYST_BITS-1:0];
        else if (idx == REG_MIN_STABLE_FRAMES)
            stable_frames = data[MIN_FRAMES_BITS-1:0];
    endtask

    // Enter and leave at a rising edge; valid stays high for the next word.
    task automatic send_snr(input snr_t s);
        int gap;
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            meas.valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
        end
        meas.valid     <= 1'b1;
        meas.snr_level <= s;
        @(posedge clk);
        while (!meas.ready)
            @(posedge clk);
        pending_sel.push_back(select_mode(s));
    endtask

    // Drop valid and hold until every selection word is back.
    task automatic wait_idle();
        meas.valid <= 1'b0;
        while (pending_sel.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic test_thresholds();
        int levels[16] = '{740, 769, 768, 704, 641, 640, 577, 576,
                           545, 544, 513, 512, 449, 448, -2048, 2047};
        foreach (levels[i])
            send_snr(snr_t'(levels[i]));
    endtask

    task automatic test_zero_registers();
        wait_idle();
        write_reg(REG_HYSTERESIS_LEVEL, cfg_data_t'(0));
        write_reg(REG_MIN_STABLE_FRAMES, cfg_data_t'(16'hFFFF));
        send_snr(snr_t'(600));
        send_snr(snr_t'(700));
        send_snr(snr_t'(2047));
        wait_idle();
        write_reg(REG_HYSTERESIS_LEVEL, cfg_data_t'(10'h3FF));
        write_reg(REG_MIN_STABLE_FRAMES, cfg_data_t'(0));
        send_snr(snr_t'(500));
        send_snr(snr_t'(760));
        send_snr(snr_t'(-5));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        hold_request  = 60;
        repeat (30)
            send_snr(snr_t'($urandom));
        wait_idle();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int        sent;
        int        base;
        int        spread;
        int        run;
        cfg_data_t value;
        for (int p = 0; p < phases; p++)
        begin
            wait_idle();
            // no idling in the closing phases
            if (p >= phases - 2)
            begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end
            case ($urandom_range(0, 4))
                0:       value = 0;
                1:       value = 1023;
                2:       value = $urandom_range(1, 64);
                3:       value = $urandom_range(0, 1023);
                default: value = $urandom_range(0, 65535);
            endcase
            write_reg(REG_HYSTERESIS_LEVEL, value);
            case ($urandom_range(0, 5))
                0:       value = 0;
                1:       value = 65535;
                2, 3:    value = $urandom_range(1, 4);
                4:       value = $urandom_range(5, 12);
                default: value = $urandom_range(0, 65535);
            endcase
            write_reg(REG_MIN_STABLE_FRAMES, value);
            sent = 0;
            while (sent < per_phase)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_snr(snr_t'($urandom));
                    sent++;
                end
                else
                begin
                    // dwell near one level, then step to another
                    base   = int'($urandom_range(380, 860));
                    spread = int'($urandom_range(0, 10));
                    run    = int'($urandom_range(1, 60));
                    if (run > per_phase - sent)
                        run = per_phase - sent;
                    repeat (run)
                    begin
                        send_snr(snr_t'(base + int'($urandom_range(0, 2 * spread)) - spread));
                        sent++;
                    end
                end
            end
        end
    endtask

    initial
    begin
        sel.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                sel.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                sel.ready <= 1'b1;
            end
            else if (receiver_idle && $urandom_range(0, 3) == 0)
            begin
                sel.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                sel.ready <= 1'b1;
            end
            else
                sel.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sel_word_t want;
        if (rst_n && sel.valid && sel.ready)
        begin
            if (pending_sel.size() == 0)
                report_mismatch("word with nothing pending", sel.switched, 0);
            else
            begin
                want = pending_sel.pop_front();
                if (sel.switched !== want.switched)
                    report_mismatch("switched", sel.switched, want.switched);
                if (sel.current_modulation !== want.cur_mod)
                    report_mismatch("current_modulation", sel.current_modulation,
                                    want.cur_mod);
                if (sel.current_code_rate !== want.cur_rate)
                    report_mismatch("current_code_rate", sel.current_code_rate,
                                    want.cur_rate);
                if (sel.recommended_modulation !== want.table_mod)
                    report_mismatch("recommended_modulation", sel.recommended_modulation,
                                    want.table_mod);
                if (sel.recommended_code_rate !== want.table_rate)
                    report_mismatch("recommended_code_rate", sel.recommended_code_rate,
                                    want.table_rate);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((meas.valid && meas.ready) || (sel.valid && sel.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_HYSTERESIS_LEVEL;
        cfg_data       = '0;
        meas.valid     = 1'b0;
        meas.snr_level = '0;
        sender_idle    = 1'b1;
        receiver_idle  = 1'b1;
        hold_request   = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        mode_mod       = MOD_RESET;
        mode_rate      = RATE_RESET;
        snr_at_switch  = '0;
        frames_held    = '0;
        hyst_level     = HYST_RESET;
        stable_frames  = MIN_FRAMES_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_thresholds();
        test_zero_registers();
        test_output_backpressure();
        test_random_phases(13, 110);

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
